[hw/rtl/mrer_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the multi-reader event ring.
package mrer_pkg;

    // Request kinds
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_SUBSCRIBE   = 3'd0;
    localparam t_kind KIND_UNSUBSCRIBE = 3'd1;
    localparam t_kind KIND_APPEND      = 3'd2;
    localparam t_kind KIND_CONSUME     = 3'd3;
    localparam t_kind KIND_SKIP        = 3'd4;
    localparam t_kind KIND_CLEAR       = 3'd5;

    // Result status codes
    typedef logic [2:0] t_status;
    localparam t_status STATUS_OK       = 3'd0;
    localparam t_status STATUS_FULL     = 3'd1;
    localparam t_status STATUS_NO_SLOT  = 3'd2;
    localparam t_status STATUS_INACTIVE = 3'd3;
    localparam t_status STATUS_EMPTY    = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take the request on the input ports
        logic step;     // issue the next event of a running burst
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic burst_go;    // accepted consume delivers more than one event
        logic burst_last;  // this step issues the final event
    } t_dp_stat;

endpackage

[hw/rtl/mrer_ctrl.sv]
`timescale 1ns / 1ps
// Request controller: idle / burst state machine for the event ring.
module mrer_ctrl import mrer_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd,
    output logic     o_busy
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_BURST = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Commands
    assign w_accept     = i_start && (r_state == S_IDLE);
    assign o_cmd.accept = w_accept;
    assign o_cmd.step   = (r_state == S_BURST);
    assign o_busy       = (r_state == S_BURST);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_stat.burst_go) n_state = S_BURST;
            end
            S_BURST: begin
                if (i_stat.burst_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/mrer_dp.sv]
`timescale 1ns / 1ps
// Event ring datapath: event memory, write/read pointers, slot table, result registers.
module mrer_dp import mrer_pkg::*; #(
    parameter int CAPACITY    = 256,
    parameter int SUBSCRIBERS = 8,
    parameter int EVENT_BITS  = 32,
    parameter int MAX_BURST   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_dp_stat    o_stat,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_subscriber,
    input  logic [31:0] i_event_data,
    input  logic [6:0]  i_max_events,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot_id,
    output logic [31:0] o_event_out,
    output logic        o_event_valid,
    output logic [6:0]  o_delivered,
    output logic        o_last
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = (SUBSCRIBERS > 1) ? $clog2(SUBSCRIBERS) : 1;
    localparam int DW = (EVENT_BITS < 32) ? EVENT_BITS : 32;
    localparam logic [AW-1:0] LAST_IDX  = AW'(CAPACITY - 1);
    localparam logic [6:0]    BURST_MAX = 7'(MAX_BURST);

    // Event memory, one write and one read port
    logic [DW-1:0] mem [CAPACITY];
    logic [DW-1:0] r_rdata;

    // Pointers are {wrap, index}; index runs 0..CAPACITY-1
    logic [AW-1:0] r_wp_idx, n_wp_idx;
    logic          r_wp_wrap, n_wp_wrap;
    logic [AW-1:0] r_rp_idx  [SUBSCRIBERS];
    logic [AW-1:0] n_rp_idx  [SUBSCRIBERS];
    logic          r_rp_wrap [SUBSCRIBERS];
    logic          n_rp_wrap [SUBSCRIBERS];
    logic [SUBSCRIBERS-1:0] r_active, n_active;

    // Burst working state
    logic [AW-1:0] r_cur_idx, n_cur_idx;
    logic          r_cur_wrap, n_cur_wrap;
    logic [6:0]    r_cnt, n_cnt;
    logic [6:0]    r_want, n_want;
    logic [SW-1:0] r_sub, n_sub;

    // Result registers
    logic          r_strobe;
    t_status       r_status;
    logic [2:0]    r_slot;
    logic          r_evalid;
    logic [6:0]    r_delivered;
    logic          r_last;

    // Request decode
    logic [SW-1:0] sub_idx;
    logic          valid_sub, sub_ok;
    logic [AW-1:0] rp_idx_s;
    logic          rp_wrap_s;
    logic [6:0]    want_c;
    logic          empty_s;
    logic          free_found;
    logic [SW-1:0] free_slot;
    logic          any_active, ring_full;

    // Event issue
    logic [AW-1:0] cur_idx, nxt_idx, wp_nxt_idx;
    logic          cur_wrap, nxt_wrap;
    logic [6:0]    cnt_sel, want_sel;
    logic          last_b;

    // Per-request results
    logic          issue, deliver, mem_we;
    t_status       res_status;
    logic [2:0]    res_slot;
    logic [6:0]    res_delivered;
    logic          res_last;

    assign sub_idx   = SW'(i_subscriber);
    assign valid_sub = (32'(i_subscriber) < SUBSCRIBERS);
    assign sub_ok    = valid_sub && r_active[sub_idx];
    assign rp_idx_s  = r_rp_idx[sub_idx];
    assign rp_wrap_s = r_rp_wrap[sub_idx];
    assign empty_s   = (rp_idx_s == r_wp_idx) && (rp_wrap_s == r_wp_wrap);
    assign want_c    = (i_max_events > BURST_MAX) ? BURST_MAX : i_max_events;
    assign any_active = |r_active;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SUBSCRIBERS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    // Full: some active reader is a whole ring behind the writer
    always_comb begin
        ring_full = 1'b0;
        for (int i = 0; i < SUBSCRIBERS; i++) begin
            if (r_active[i] && (r_rp_wrap[i] != r_wp_wrap) && (r_rp_idx[i] == r_wp_idx))
                ring_full = 1'b1;
        end
    end

    // Read pointer of the event being issued and its successor
    assign cur_idx  = i_cmd.step ? r_cur_idx  : rp_idx_s;
    assign cur_wrap = i_cmd.step ? r_cur_wrap : rp_wrap_s;
    assign nxt_idx  = (cur_idx == LAST_IDX) ? '0 : cur_idx + AW'(1);
    assign nxt_wrap = cur_wrap ^ (cur_idx == LAST_IDX);
    assign wp_nxt_idx = (r_wp_idx == LAST_IDX) ? '0 : r_wp_idx + AW'(1);
    assign cnt_sel  = i_cmd.step ? r_cnt + 7'd1 : 7'd1;
    assign want_sel = i_cmd.step ? r_want : want_c;
    assign last_b   = (cnt_sel == want_sel) || ((nxt_idx == r_wp_idx) && (nxt_wrap == r_wp_wrap));

    // Request execution
    always_comb begin
        n_wp_idx   = r_wp_idx;
        n_wp_wrap  = r_wp_wrap;
        n_rp_idx   = r_rp_idx;
        n_rp_wrap  = r_rp_wrap;
        n_active   = r_active;
        n_cur_idx  = r_cur_idx;
        n_cur_wrap = r_cur_wrap;
        n_cnt      = r_cnt;
        n_want     = r_want;
        n_sub      = r_sub;
        issue         = 1'b0;
        deliver       = 1'b0;
        mem_we        = 1'b0;
        res_status    = STATUS_OK;
        res_slot      = 3'd0;
        res_delivered = 7'd0;
        res_last      = 1'b1;
        o_stat.burst_go   = 1'b0;
        o_stat.burst_last = 1'b0;

        if (i_cmd.step) begin
            issue         = 1'b1;
            deliver       = 1'b1;
            res_delivered = cnt_sel;
            res_last      = last_b;
            n_cur_idx     = nxt_idx;
            n_cur_wrap    = nxt_wrap;
            n_cnt         = cnt_sel;
            o_stat.burst_last = last_b;
            if (last_b) begin
                n_rp_idx[r_sub]  = nxt_idx;
                n_rp_wrap[r_sub] = nxt_wrap;
            end
        end else if (i_cmd.accept) begin
            case (i_kind)
                KIND_SUBSCRIBE: begin
                    issue = 1'b1;
                    if (free_found) begin
                        n_active[free_slot]  = 1'b1;
                        n_rp_idx[free_slot]  = r_wp_idx;
                        n_rp_wrap[free_slot] = r_wp_wrap;
                        res_slot = 3'(free_slot);
                    end else begin
                        res_status = STATUS_NO_SLOT;
                    end
                end
                KIND_UNSUBSCRIBE: begin
                    issue = 1'b1;
                    if (sub_ok) begin
                        n_active[sub_idx]  = 1'b0;
                        n_rp_idx[sub_idx]  = '0;
                        n_rp_wrap[sub_idx] = 1'b0;
                    end else begin
                        res_status = STATUS_INACTIVE;
                    end
                end
                KIND_APPEND: begin
                    issue = 1'b1;
                    if (any_active) begin
                        if (ring_full) begin
                            res_status = STATUS_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            n_wp_idx  = wp_nxt_idx;
                            n_wp_wrap = r_wp_wrap ^ (r_wp_idx == LAST_IDX);
                        end
                    end
                end
                KIND_CONSUME: begin
                    issue = 1'b1;
                    if (!sub_ok) begin
                        res_status = STATUS_INACTIVE;
                    end else if (empty_s || (want_c == 7'd0)) begin
                        res_status = STATUS_EMPTY;
                    end else begin
                        deliver       = 1'b1;
                        res_delivered = 7'd1;
                        res_last      = last_b;
                        if (last_b) begin
                            n_rp_idx[sub_idx]  = nxt_idx;
                            n_rp_wrap[sub_idx] = nxt_wrap;
                        end else begin
                            o_stat.burst_go = 1'b1;
                            n_cur_idx  = nxt_idx;
                            n_cur_wrap = nxt_wrap;
                            n_cnt      = 7'd1;
                            n_want     = want_c;
                            n_sub      = sub_idx;
                        end
                    end
                end
                KIND_SKIP: begin
                    issue = 1'b1;
                    if (sub_ok) begin
                        n_rp_idx[sub_idx]  = r_wp_idx;
                        n_rp_wrap[sub_idx] = r_wp_wrap;
                    end else begin
                        res_status = STATUS_INACTIVE;
                    end
                end
                KIND_CLEAR: begin
                    issue     = 1'b1;
                    n_wp_idx  = '0;
                    n_wp_wrap = 1'b0;
                    for (int i = 0; i < SUBSCRIBERS; i++) begin
                        if (r_active[i]) begin
                            n_rp_idx[i]  = '0;
                            n_rp_wrap[i] = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Event memory
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_wp_idx] <= i_event_data[DW-1:0];
        r_rdata <= mem[cur_idx];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp_idx  <= '0;
            r_wp_wrap <= 1'b0;
            r_active  <= '0;
            r_strobe  <= 1'b0;
            for (int i = 0; i < SUBSCRIBERS; i++) begin
                r_rp_idx[i]  <= '0;
                r_rp_wrap[i] <= 1'b0;
            end
        end else begin
            r_wp_idx  <= n_wp_idx;
            r_wp_wrap <= n_wp_wrap;
            r_active  <= n_active;
            r_strobe  <= issue;
            r_rp_idx  <= n_rp_idx;
            r_rp_wrap <= n_rp_wrap;
        end
    end

    // Burst working registers and result payload
    always_ff @(posedge i_clk) begin
        r_cur_idx   <= n_cur_idx;
        r_cur_wrap  <= n_cur_wrap;
        r_cnt       <= n_cnt;
        r_want      <= n_want;
        r_sub       <= n_sub;
        r_status    <= res_status;
        r_slot      <= res_slot;
        r_evalid    <= deliver;
        r_delivered <= res_delivered;
        r_last      <= res_last;
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_slot_id     = r_slot;
    assign o_event_out   = r_evalid ? 32'(r_rdata) : 32'd0;
    assign o_event_valid = r_evalid;
    assign o_delivered   = r_delivered;
    assign o_last        = r_last;

endmodule

[hw/rtl/multi_reader_event_ring_unit.sv]
`timescale 1ns / 1ps
// Top level of the multi-reader event ring.
//
// A broadcast ring of CAPACITY events with one read pointer per subscriber slot.
// A request is taken when start is high and busy is low. Subscribe, unsubscribe,
// append, skip and clear give one result each; a consume that delivers n events
// gives n results back to back and holds busy high while all but the first are
// issued, since the single read port of the event memory yields one event per
// cycle. Each result appears on the o_ ports for one cycle with o_strobe high,
// in the cycle after it is issued; there is no stall from the receiver, so
// every strobe must be taken. Kinds 6 and 7 are ignored with no result.
// An append onto a ring whose slowest active reader is CAPACITY events
// behind is dropped with status 1; with no active subscriber it is dropped with
// status 0. No clearing pass after reset: the event memory is only read where
// an append has written it.
module multi_reader_event_ring_unit import mrer_pkg::*; #(
    parameter int CAPACITY    = 256,
    parameter int SUBSCRIBERS = 8,
    parameter int EVENT_BITS  = 32,
    parameter int MAX_BURST   = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_kind,
    input  logic [2:0]  i_subscriber,
    input  logic [31:0] i_event_data,
    input  logic [6:0]  i_max_events,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [2:0]  o_slot_id,
    output logic [31:0] o_event_out,
    output logic        o_event_valid,
    output logic [6:0]  o_delivered,
    output logic        o_last
);

    t_cmd     cmd;
    t_dp_stat dp_stat;

    // Controller
    mrer_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Datapath
    mrer_dp #(
        .CAPACITY    (CAPACITY),
        .SUBSCRIBERS (SUBSCRIBERS),
        .EVENT_BITS  (EVENT_BITS),
        .MAX_BURST   (MAX_BURST)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (dp_stat),
        .i_kind        (i_kind),
        .i_subscriber  (i_subscriber),
        .i_event_data  (i_event_data),
        .i_max_events  (i_max_events),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_slot_id     (o_slot_id),
        .o_event_out   (o_event_out),
        .o_event_valid (o_event_valid),
        .o_delivered   (o_delivered),
        .o_last        (o_last)
    );

endmodule

[hw/rtl/mrer_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the event ring, bound to the top level.
module mrer_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_kind,
    input logic [2:0]  i_subscriber,
    input logic [31:0] i_event_data,
    input logic [6:0]  i_max_events,
    input logic        o_strobe,
    input logic [2:0]  o_status,
    input logic [2:0]  o_slot_id,
    input logic [31:0] o_event_out,
    input logic        o_event_valid,
    input logic [6:0]  o_delivered,
    input logic        o_last
);

    // A burst continues without gaps until its last event
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("burst result missing after non-final result");

    // Only consume events come as non-final results
    a_nonlast_is_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> o_event_valid)
        else $error("non-final result without an event");

    // Delivered count steps by one within a burst
    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_delivered == $past(o_delivered) + 7'd1)
        else $error("delivered count did not advance");

    // A defined request always answers on the next cycle
    a_request_answered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind != 3'd6 && i_kind != 3'd7 |=> o_strobe)
        else $error("accepted request gave no result");

    // Results without an event are single and carry no count
    a_plain_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_event_valid |-> o_last && o_delivered == 7'd0)
        else $error("malformed non-event result");

endmodule

bind multi_reader_event_ring_unit mrer_chk u_mrer_chk (.*);
